FILE: design/jbp_pkg.sv
// ----------------------------------------------------------------------------
// jbp_pkg
// shared types and constants of the joy bus port register block
// ----------------------------------------------------------------------------
package jbp_pkg;

  // command kinds
  localparam logic [2:0] KIND_BUS_WR     = 3'd0;
  localparam logic [2:0] KIND_BUS_RD     = 3'd1;
  localparam logic [2:0] KIND_LINK_RST   = 3'd2;
  localparam logic [2:0] KIND_LINK_POLL  = 3'd3;
  localparam logic [2:0] KIND_LINK_RECV  = 3'd4;
  localparam logic [2:0] KIND_LINK_TRANS = 3'd5;

  // register selects
  localparam logic [2:0] REG_CTRL     = 3'd0;
  localparam logic [2:0] REG_STAT     = 3'd1;
  localparam logic [2:0] REG_RECV_LO  = 3'd2;
  localparam logic [2:0] REG_RECV_HI  = 3'd3;
  localparam logic [2:0] REG_TRANS_LO = 3'd4;
  localparam logic [2:0] REG_TRANS_HI = 3'd5;

  // control word flags
  localparam logic [15:0] CNT_RESET  = 16'h0001;
  localparam logic [15:0] CNT_RECV   = 16'h0002;
  localparam logic [15:0] CNT_TRANS  = 16'h0004;
  localparam logic [15:0] CNT_FLAGS  = 16'h0007;
  localparam logic [15:0] CNT_IRQ_EN = 16'h0040;
  localparam int unsigned CNT_IRQ_BIT = 6;

  // status word flags
  localparam logic [15:0] STAT_RECV  = 16'h0002;
  localparam logic [15:0] STAT_TRANS = 16'h0008;
  localparam logic [15:0] STAT_GP    = 16'h0030;

  // fixed reply bytes of reset and poll
  localparam logic [7:0] REPLY_ID_LO = 8'h00;
  localparam logic [7:0] REPLY_ID_HI = 8'h04;

  // one classified command waiting for the serializer
  typedef struct packed {
    logic        is_bus;    // single beat carrying read_data
    logic        irq;       // raise irq on the first beat
    logic [2:0]  last_idx;  // index of the final beat
    logic [39:0] data;      // bus: read value in [15:0]; link: reply bytes, first in [7:0]
  } jbp_job_t;

endpackage

FILE: design/joy_bus_port_registers_top.sv
// ----------------------------------------------------------------------------
// joy_bus_port_registers_top
// device side of a joypad-style serial port: cpu registers and link replies
// ----------------------------------------------------------------------------
// usage
//   input channel: one beat per command (in_kind, in_reg_select, in_write_data,
//   in_recv_word), taken when in_valid is high and in_stall is low
//   output channel: one beat per result; out_last marks the final beat of
//   a command (bus write/read and receive give 1 beat, reset/poll 3,
//   transmit 5); unused kinds give none
//   a taken command is queued at its accepting edge; the serializer later
//   loads its first beat from the queue head into the output register,
//   from which the beat shows on the port
//   the serializer emits one result beat per cycle while a job is queued and
//   out_stall is low, and ends a command with its last beat (transmit has 5);
//   the decoder takes a new command each cycle while the job queue has room
//   a stalled output holds its beat; the queue keeps accepting until full,
//   then in_stall rises
//   reset (rst_n low, synchronous) clears all cpu registers, empties the queue
//   and drops out_valid
// ----------------------------------------------------------------------------
module joy_bus_port_registers_top
  import jbp_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
)
(
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_kind,
  input  logic [2:0]  in_reg_select,
  input  logic [15:0] in_write_data,
  input  logic [31:0] in_recv_word,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_reply_byte,
  output logic [15:0] out_read_data,
  output logic        out_irq,
  output logic        out_last
);

  // decoder to queue
  logic     q_full, q_push;
  jbp_job_t q_job;

  // queue to serializer
  logic     head_valid, q_pop;
  jbp_job_t head_job;

  // front: owns the register state, updates it on accept and snapshots
  // every reply byte the command will need
  jbp_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_reg_select (in_reg_select),
    .in_write_data (in_write_data),
    .in_recv_word  (in_recv_word),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_job         (q_job)
  );

  // decouples decoding from the slow multi-beat replies
  jbp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // back: walks the head job beat by beat into the output register
  jbp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (head_valid),
    .head_job       (head_job),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_reply_byte (out_reply_byte),
    .out_read_data  (out_read_data),
    .out_irq        (out_irq),
    .out_last       (out_last)
  );

endmodule

FILE: design/jbp_front.sv
// ----------------------------------------------------------------------------
// jbp_front
// register file and command decoder: applies each command and queues its replies
// ----------------------------------------------------------------------------
module jbp_front
  import jbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_kind,
  input  logic [2:0]  in_reg_select,
  input  logic [15:0] in_write_data,
  input  logic [31:0] in_recv_word,
  input  logic        q_full,
  output logic        q_push,
  output jbp_job_t    q_job
);

  logic [15:0] ctrl_r, stat_r, recv_lo_r, recv_hi_r, trans_lo_r, trans_hi_r;
  logic [15:0] ctrl_nxt, stat_nxt, recv_lo_nxt, recv_hi_nxt, trans_lo_nxt, trans_hi_nxt;
  logic [15:0] reg_val;
  logic        accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    ctrl_nxt     = ctrl_r;
    stat_nxt     = stat_r;
    recv_lo_nxt  = recv_lo_r;
    recv_hi_nxt  = recv_hi_r;
    trans_lo_nxt = trans_lo_r;
    trans_hi_nxt = trans_hi_r;
    unique case (in_kind)
      KIND_BUS_WR: begin
        case (in_reg_select)
          REG_CTRL:     ctrl_nxt = (in_write_data & CNT_IRQ_EN) |
                                   (ctrl_r & ~(in_write_data & CNT_FLAGS) & ~CNT_IRQ_EN);
          REG_STAT:     stat_nxt = (in_write_data & STAT_GP) | (stat_r & ~STAT_GP);
          REG_RECV_LO:  recv_lo_nxt  = in_write_data;
          REG_RECV_HI:  recv_hi_nxt  = in_write_data;
          REG_TRANS_LO: trans_lo_nxt = in_write_data;
          REG_TRANS_HI: trans_hi_nxt = in_write_data;
          default: ;
        endcase
      end
      KIND_LINK_RST: ctrl_nxt = ctrl_r | CNT_RESET;
      KIND_LINK_RECV: begin
        ctrl_nxt    = ctrl_r | CNT_RECV;
        stat_nxt    = stat_r | STAT_RECV;
        recv_lo_nxt = in_recv_word[15:0];
        recv_hi_nxt = in_recv_word[31:16];
      end
      KIND_LINK_TRANS: begin
        ctrl_nxt = ctrl_r | CNT_TRANS;
        stat_nxt = stat_r & ~STAT_TRANS;
      end
      default: ;
    endcase
  end

  // read value after the update
  always_comb begin
    case (in_reg_select)
      REG_CTRL:     reg_val = ctrl_nxt;
      REG_STAT:     reg_val = stat_nxt;
      REG_RECV_LO:  reg_val = recv_lo_nxt;
      REG_RECV_HI:  reg_val = recv_hi_nxt;
      REG_TRANS_LO: reg_val = trans_lo_nxt;
      REG_TRANS_HI: reg_val = trans_hi_nxt;
      default:      reg_val = 16'h0000;
    endcase
  end

  always_comb begin
    q_job  = '0;
    q_push = accept;
    unique case (in_kind)
      KIND_BUS_WR, KIND_BUS_RD: begin
        q_job.is_bus = 1'b1;
        q_job.data   = {24'h0, reg_val};
      end
      KIND_LINK_RST, KIND_LINK_POLL: begin
        q_job.irq      = (in_kind == KIND_LINK_RST) && ctrl_nxt[CNT_IRQ_BIT];
        q_job.last_idx = 3'd2;
        q_job.data     = {16'h0, stat_nxt[7:0], REPLY_ID_HI, REPLY_ID_LO};
      end
      KIND_LINK_RECV: begin
        q_job.irq  = ctrl_nxt[CNT_IRQ_BIT];
        q_job.data = {32'h0, stat_nxt[7:0]};
      end
      KIND_LINK_TRANS: begin
        q_job.irq      = ctrl_nxt[CNT_IRQ_BIT];
        q_job.last_idx = 3'd4;
        q_job.data     = {stat_nxt[7:0], trans_hi_r, trans_lo_r};
      end
      default: q_push = 1'b0;  // unused kinds give no beats
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r     <= '0;
      stat_r     <= '0;
      recv_lo_r  <= '0;
      recv_hi_r  <= '0;
      trans_lo_r <= '0;
      trans_hi_r <= '0;
    end else if (accept) begin
      ctrl_r     <= ctrl_nxt;
      stat_r     <= stat_nxt;
      recv_lo_r  <= recv_lo_nxt;
      recv_hi_r  <= recv_hi_nxt;
      trans_lo_r <= trans_lo_nxt;
      trans_hi_r <= trans_hi_nxt;
    end
  end

endmodule

FILE: design/jbp_queue.sv
// ----------------------------------------------------------------------------
// jbp_queue
// short job queue between the decoder and the serializer
// ----------------------------------------------------------------------------
module jbp_queue
  import jbp_pkg::*;
#(
  parameter int unsigned DEPTH = 2
)
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  jbp_job_t push_job,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output jbp_job_t head_job
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  jbp_job_t      slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full       = (count_r == CNT_FULL);
  assign head_valid = (count_r != '0);
  assign head_job   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

FILE: design/jbp_back.sv
// ----------------------------------------------------------------------------
// jbp_back
// reply serializer: turns each queued job into its result beats
// ----------------------------------------------------------------------------
module jbp_back
  import jbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  jbp_job_t    head_job,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_reply_byte,
  output logic [15:0] out_read_data,
  output logic        out_irq,
  output logic        out_last
);

  logic [2:0]  idx_r;
  logic        valid_r;
  logic [7:0]  reply_r;
  logic [15:0] data_r;
  logic        irq_r, last_r;
  logic        load, emit, is_last;
  logic [7:0]  byte_sel;

  assign load    = !valid_r || !out_stall;
  assign emit    = load && head_valid;
  assign is_last = (idx_r == head_job.last_idx);
  assign pop     = emit && is_last;

  always_comb begin
    case (idx_r)
      3'd0:    byte_sel = head_job.data[7:0];
      3'd1:    byte_sel = head_job.data[15:8];
      3'd2:    byte_sel = head_job.data[23:16];
      3'd3:    byte_sel = head_job.data[31:24];
      default: byte_sel = head_job.data[39:32];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      if (load) begin
        valid_r <= head_valid;
      end
      if (emit) begin
        idx_r <= is_last ? 3'd0 : idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      reply_r <= head_job.is_bus ? 8'h00 : byte_sel;
      data_r  <= head_job.is_bus ? head_job.data[15:0] : 16'h0000;
      irq_r   <= head_job.irq && (idx_r == 3'd0);
      last_r  <= is_last;
    end
  end

  assign out_valid      = valid_r;
  assign out_reply_byte = reply_r;
  assign out_read_data  = data_r;
  assign out_irq        = irq_r;
  assign out_last       = last_r;

endmodule

FILE: design/jbp_checker.sv
// ----------------------------------------------------------------------------
// jbp_checker
// port-level checks of the joy bus port register block
// ----------------------------------------------------------------------------
module jbp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_reply_byte,
  input logic [15:0] out_read_data,
  input logic        out_irq,
  input logic        out_last
);

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output beat right after reset");

  // a stalled beat stays
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled beat dropped");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_reply_byte) && $stable(out_read_data) &&
                               $stable(out_irq) && $stable(out_last))
    else $error("stalled beat changed");

  // bus beats never carry irq or a reply byte
  a_bus_or_link: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_read_data == 16'h0000) || (out_reply_byte == 8'h00 && !out_irq))
    else $error("beat mixes bus data with link reply");

  // irq only on the first beat of a command
  a_irq_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> !out_valid || !out_irq)
    else $error("irq on a later beat");

endmodule

bind joy_bus_port_registers_top jbp_checker u_jbp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_reply_byte (out_reply_byte),
  .out_read_data  (out_read_data),
  .out_irq        (out_irq),
  .out_last       (out_last)
);

FILE: bench/tb_joy_bus_port_registers_top.sv
// ----------------------------------------------------------------------------
// tb_joy_bus_port_registers_top
// self-checking bench for the joy bus port register block: a directed table
// of cpu accesses and link commands, then random traffic under bursty input
// and patterned output stall, each beat checked against a typed row or predictor
// ----------------------------------------------------------------------------
module tb_joy_bus_port_registers_top;
  import jbp_pkg::*;

  // kinds and selects the block does not decode
  localparam logic [2:0] KIND_SPARE_6 = 3'd6;
  localparam logic [2:0] KIND_SPARE_7 = 3'd7;
  localparam logic [2:0] REG_SPARE_6  = 3'd6;
  localparam logic [2:0] REG_SPARE_7  = 3'd7;

  localparam int unsigned RANDOM_CMDS = 128;
  localparam int unsigned SETTLE_CYCLES = 20;

  // one command, with an optional hand-written first result beat
  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  sel;
    logic [15:0] wdata;
    logic [31:0] rword;
    logic        typed;
    logic [7:0]  t_reply;
    logic [15:0] t_data;
    logic        t_irq;
    logic        t_last;
  } cmd_row_t;

  // one result beat as the port shows it
  typedef struct packed {
    logic [7:0]  reply;
    logic [15:0] data;
    logic        irq;
    logic        last;
  } beat_t;

  typedef enum logic [1:0] {SINK_OPEN, SINK_RANDOM, SINK_BURSTY} sink_mode_t;

  // directed table: reset values, register extremes, irq on and off,
  // unmapped selects and undecoded kinds
  localparam int unsigned N_DIRECTED = 27;
  localparam cmd_row_t DIRECTED [N_DIRECTED] = '{
    '{KIND_BUS_RD,     REG_CTRL,     16'h0000, 32'h0, 1'b1, 8'h00, 16'h0000, 1'b0, 1'b1},
    '{KIND_BUS_RD,     REG_STAT,     16'h0000, 32'h0, 1'b1, 8'h00, 16'h0000, 1'b0, 1'b1},
    '{KIND_BUS_RD,     REG_TRANS_HI, 16'h0000, 32'h0, 1'b1, 8'h00, 16'h0000, 1'b0, 1'b1},
    '{KIND_LINK_POLL,  REG_CTRL,     16'h0000, 32'h0, 1'b1, 8'h00, 16'h0000, 1'b0, 1'b0},
    '{KIND_LINK_RST,   REG_CTRL,     16'h0000, 32'h0, 1'b1, 8'h00, 16'h0000, 1'b0, 1'b0},
    '{KIND_BUS_WR,     REG_CTRL,     16'hFFFF, 32'h0, 1'b1, 8'h00, 16'h0040, 1'b0, 1'b1},
    '{KIND_BUS_WR,     REG_CTRL,     16'h0000, 32'h0, 1'b1, 8'h00, 16'h0000, 1'b0, 1'b1},
    '{KIND_BUS_WR,     REG_CTRL,     16'h0040, 32'h0, 1'b1, 8'h00, 16'h0040, 1'b0, 1'b1},
    '{KIND_LINK_RST,   REG_CTRL,     16'h0000, 32'h0, 1'b1, 8'h00, 16'h0000, 1'b1, 1'b0},
    '{KIND_LINK_POLL,  REG_CTRL,     16'h0000, 32'h0, 1'b1, 8'h00, 16'h0000, 1'b0, 1'b0},
    '{KIND_BUS_WR,     REG_STAT,     16'hFFFF, 32'h0, 1'b1, 8'h00, 16'h0030, 1'b0, 1'b1},
    '{KIND_BUS_WR,     REG_TRANS_LO, 16'hFFFF, 32'h0, 1'b1, 8'h00, 16'hFFFF, 1'b0, 1'b1},
    '{KIND_BUS_WR,     REG_TRANS_HI, 16'h0000, 32'h0, 1'b1, 8'h00, 16'h0000, 1'b0, 1'b1},
    '{KIND_LINK_TRANS, REG_CTRL,     16'h0000, 32'h0, 1'b1, 8'hFF, 16'h0000, 1'b1, 1'b0},
    '{KIND_LINK_RECV,  REG_CTRL,     16'h0000, 32'hFFFFFFFF, 1'b0, 8'h00, 16'h0, 1'b0, 1'b0},
    '{KIND_BUS_RD,     REG_RECV_HI,  16'h0000, 32'h0, 1'b1, 8'h00, 16'hFFFF, 1'b0, 1'b1},
    '{KIND_LINK_RECV,  REG_CTRL,     16'h0000, 32'h0, 1'b0, 8'h00, 16'h0000, 1'b0, 1'b0},
    '{KIND_BUS_RD,     REG_RECV_LO,  16'h0000, 32'h0, 1'b1, 8'h00, 16'h0000, 1'b0, 1'b1},
    '{KIND_BUS_WR,     REG_STAT,     16'h0000, 32'h0, 1'b0, 8'h00, 16'h0000, 1'b0, 1'b0},
    '{KIND_BUS_WR,     REG_CTRL,     16'h0007, 32'h0, 1'b1, 8'h00, 16'h0000, 1'b0, 1'b1},
    '{KIND_BUS_WR,     REG_SPARE_6,  16'h1234, 32'h0, 1'b1, 8'h00, 16'h0000, 1'b0, 1'b1},
    '{KIND_BUS_RD,     REG_SPARE_7,  16'h0000, 32'h0, 1'b1, 8'h00, 16'h0000, 1'b0, 1'b1},
    '{KIND_SPARE_6,    REG_CTRL,     16'hFFFF, 32'hFFFFFFFF, 1'b0, 8'h00, 16'h0, 1'b0, 1'b0},
    '{KIND_SPARE_7,    REG_SPARE_7,  16'hFFFF, 32'hFFFFFFFF, 1'b0, 8'h00, 16'h0, 1'b0, 1'b0},
    '{KIND_LINK_TRANS, REG_CTRL,     16'h0000, 32'h0, 1'b0, 8'h00, 16'h0000, 1'b0, 1'b0},
    '{KIND_BUS_WR,     REG_TRANS_LO, 16'hA5C3, 32'h0, 1'b0, 8'h00, 16'h0000, 1'b0, 1'b0},
    '{KIND_BUS_RD,     REG_TRANS_LO, 16'h0000, 32'h0, 1'b0, 8'h00, 16'h0000, 1'b0, 1'b0}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_kind;
  logic [2:0]  in_reg_select;
  logic [15:0] in_write_data;
  logic [31:0] in_recv_word;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_reply_byte;
  logic [15:0] out_read_data;
  logic        out_irq;
  logic        out_last;

  // predictor copy of the register file
  logic [15:0] ctrl_w, stat_w, rx_lo, rx_hi, tx_lo, tx_hi;

  beat_t       expected_beats [$];  // beats still owed by the block, oldest first
  cmd_row_t    issued_cmds [$];     // commands driven, waiting for acceptance

  int unsigned errors = 0;
  int unsigned beats_checked = 0;
  int unsigned kind_count [8];

  // receiver stall pattern state
  sink_mode_t  sink_mode = SINK_OPEN;
  int unsigned sink_left = 0;
  int unsigned hold_left = 0;

  joy_bus_port_registers_top DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_reg_select  (in_reg_select),
    .in_write_data  (in_write_data),
    .in_recv_word   (in_recv_word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_reply_byte (out_reply_byte),
    .out_read_data  (out_read_data),
    .out_irq        (out_irq),
    .out_last       (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [15:0] reg_fetch(input logic [2:0] sel);
    case (sel)
      REG_CTRL:     return ctrl_w;
      REG_STAT:     return stat_w;
      REG_RECV_LO:  return rx_lo;
      REG_RECV_HI:  return rx_hi;
      REG_TRANS_LO: return tx_lo;
      REG_TRANS_HI: return tx_hi;
      default:      return 16'h0000;
    endcase
  endfunction

  task automatic owe_beat(input logic [7:0] reply, input logic [15:0] data,
                          input logic irq, input logic last);
    expected_beats.push_back('{reply, data, irq, last});
  endtask

  // apply one command to the register copy and queue the beats it owes
  task automatic model_command(input logic [2:0] kind, input logic [2:0] sel,
                               input logic [15:0] wd, input logic [31:0] rw);
    logic irq_now;
    case (kind)
      KIND_BUS_WR: begin
        case (sel)
          // irq enable follows the data, flags clear where ones are written
          REG_CTRL:     ctrl_w = (wd & CNT_IRQ_EN) | (ctrl_w & ~(wd & CNT_FLAGS) & ~CNT_IRQ_EN);
          REG_STAT:     stat_w = (wd & STAT_GP) | (stat_w & ~STAT_GP);
          REG_RECV_LO:  rx_lo = wd;
          REG_RECV_HI:  rx_hi = wd;
          REG_TRANS_LO: tx_lo = wd;
          REG_TRANS_HI: tx_hi = wd;
          default: ;
        endcase
        owe_beat(8'h00, reg_fetch(sel), 1'b0, 1'b1);
      end
      KIND_BUS_RD: owe_beat(8'h00, reg_fetch(sel), 1'b0, 1'b1);
      KIND_LINK_RST, KIND_LINK_POLL: begin
        irq_now = 1'b0;
        if (kind == KIND_LINK_RST) begin
          ctrl_w  = ctrl_w | CNT_RESET;
          irq_now = ctrl_w[CNT_IRQ_BIT];
        end
        owe_beat(REPLY_ID_LO, 16'h0000, irq_now, 1'b0);
        owe_beat(REPLY_ID_HI, 16'h0000, 1'b0, 1'b0);
        owe_beat(stat_w[7:0], 16'h0000, 1'b0, 1'b1);
      end
      KIND_LINK_RECV: begin
        ctrl_w = ctrl_w | CNT_RECV;
        stat_w = stat_w | STAT_RECV;
        rx_lo  = rw[15:0];
        rx_hi  = rw[31:16];
        owe_beat(stat_w[7:0], 16'h0000, ctrl_w[CNT_IRQ_BIT], 1'b1);
      end
      KIND_LINK_TRANS: begin
        ctrl_w = ctrl_w | CNT_TRANS;
        stat_w = stat_w & ~STAT_TRANS;
        owe_beat(tx_lo[7:0],  16'h0000, ctrl_w[CNT_IRQ_BIT], 1'b0);
        owe_beat(tx_lo[15:8], 16'h0000, 1'b0, 1'b0);
        owe_beat(tx_hi[7:0],  16'h0000, 1'b0, 1'b0);
        owe_beat(tx_hi[15:8], 16'h0000, 1'b0, 1'b0);
        owe_beat(stat_w[7:0], 16'h0000, 1'b0, 1'b1);
      end
      default: ;  // undecoded kinds owe nothing
    endcase
  endtask

  // ------------------------------------------------------------------ monitor

  // sampled at the rising edge; outputs are checked before the new command
  // is modeled, since a beat can never stem from a command taken that edge
  always @(posedge clk) begin
    beat_t    got;
    beat_t    want;
    cmd_row_t cmd;
    int       first_idx;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = '{out_reply_byte, out_read_data, out_irq, out_last};
        beats_checked++;
        if (expected_beats.size() == 0) begin
          errors++;
          $display("%0t: expected no beat, actual reply %h data %h irq %b last %b",
                   $time, got.reply, got.data, got.irq, got.last);
        end else begin
          want = expected_beats.pop_front();
          if (got.reply !== want.reply) begin
            errors++;
            $display("%0t: reply_byte expected %h actual %h", $time, want.reply, got.reply);
          end
          if (got.data !== want.data) begin
            errors++;
            $display("%0t: read_data expected %h actual %h", $time, want.data, got.data);
          end
          if (got.irq !== want.irq) begin
            errors++;
            $display("%0t: irq expected %b actual %b", $time, want.irq, got.irq);
          end
          if (got.last !== want.last) begin
            errors++;
            $display("%0t: last expected %b actual %b", $time, want.last, got.last);
          end
        end
      end
      if (in_valid && !in_stall) begin
        cmd = issued_cmds.pop_front();
        first_idx = expected_beats.size();
        kind_count[in_kind]++;
        model_command(in_kind, in_reg_select, in_write_data, in_recv_word);
        // a hand-written first beat takes the place of the predicted one
        if (cmd.typed && expected_beats.size() > first_idx)
          expected_beats[first_idx] = '{cmd.t_reply, cmd.t_data, cmd.t_irq, cmd.t_last};
      end
    end
  end

  // ----------------------------------------------------------------- receiver

  // stall pattern: stretches that never stall, stretches of sparse random stall,
  // and stretches of long stalls with short openings
  always @(negedge clk) begin
    if (sink_left == 0) begin
      sink_mode <= sink_mode_t'($urandom_range(0, 2));
      sink_left <= $urandom_range(20, 80);
    end else begin
      sink_left <= sink_left - 1;
    end
    case (sink_mode)
      SINK_OPEN:   out_stall <= 1'b0;
      SINK_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
      default: begin
        if (hold_left == 0) begin
          out_stall <= ~out_stall;
          hold_left <= out_stall ? $urandom_range(1, 3) : $urandom_range(1, 12);
        end else begin
          hold_left <= hold_left - 1;
        end
      end
    endcase
  end

  // ------------------------------------------------------------------- sender

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_command(input cmd_row_t cmd);
    issued_cmds.push_back(cmd);
    in_valid      <= 1'b1;
    in_kind       <= cmd.kind;
    in_reg_select <= cmd.sel;
    in_write_data <= cmd.wdata;
    in_recv_word  <= cmd.rword;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_gap(input int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // hold the sender until the block owes nothing
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(negedge clk);
  endtask

  initial begin
    cmd_row_t    cmd;
    int unsigned burst_left;
    int unsigned random_sent;
    int unsigned pick;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_kind       = KIND_BUS_RD;
    in_reg_select = REG_CTRL;
    in_write_data = 16'h0000;
    in_recv_word  = 32'h0;
    ctrl_w = 16'h0; stat_w = 16'h0;
    rx_lo  = 16'h0; rx_hi  = 16'h0;
    tx_lo  = 16'h0; tx_hi  = 16'h0;
    foreach (kind_count[i]) kind_count[i] = 0;

    // synchronous reset, released on a falling edge
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table, with short random gaps between rows
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_command(DIRECTED[i]);
      if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 3));
    end
    drain_results();

    // random traffic in bursts; mostly valid commands on mapped registers,
    // with a sprinkle of unmapped selects and undecoded kinds
    burst_left  = 0;
    random_sent = 0;
    while (random_sent < RANDOM_CMDS) begin
      if (burst_left == 0) begin
        idle_gap($urandom_range(1, 8));
        burst_left = $urandom_range(1, 16);
      end
      if (random_sent == RANDOM_CMDS / 2 && burst_left == 1) drain_results();
      pick = $urandom_range(0, 99);
      cmd = '0;
      if (pick < 30)      cmd.kind = KIND_BUS_WR;
      else if (pick < 52) cmd.kind = KIND_BUS_RD;
      else if (pick < 62) cmd.kind = KIND_LINK_RST;
      else if (pick < 72) cmd.kind = KIND_LINK_POLL;
      else if (pick < 84) cmd.kind = KIND_LINK_RECV;
      else if (pick < 96) cmd.kind = KIND_LINK_TRANS;
      else                cmd.kind = ($urandom_range(0, 1) != 0) ? KIND_SPARE_7 : KIND_SPARE_6;
      cmd.sel   = ($urandom_range(0, 15) < 14) ? 3'($urandom_range(0, 5))
                                               : 3'($urandom_range(6, 7));
      cmd.wdata = 16'($urandom);
      cmd.rword = $urandom;
      send_command(cmd);
      burst_left--;
      if (cmd.kind != KIND_SPARE_6 && cmd.kind != KIND_SPARE_7) random_sent++;
    end

    // wind down: wait for every owed beat, then watch for strays
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    errors += expected_beats.size();

    $display("covered %0d bus writes, %0d bus reads, %0d resets, %0d polls,",
             kind_count[KIND_BUS_WR], kind_count[KIND_BUS_RD],
             kind_count[KIND_LINK_RST], kind_count[KIND_LINK_POLL]);
    $display("%0d receives, %0d transmits, %0d undecoded; %0d result beats checked",
             kind_count[KIND_LINK_RECV], kind_count[KIND_LINK_TRANS],
             kind_count[KIND_SPARE_6] + kind_count[KIND_SPARE_7], beats_checked);
    if (errors == 0) begin
      $display("joy_bus_port_registers_top verification clean");
    end else begin
      $display("joy_bus_port_registers_top verification failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #3000000;
    $display("joy_bus_port_registers_top verification failed");
    $finish;
  end

endmodule
